FILE: hw/rtl/assert_macros.svh
// Assertion macros for the RTL of the spring force block.
// Depends on nothing; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle
`define ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle property violated");

// Implication checked in the next cycle
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle property violated");

`endif

FILE: hw/rtl/sfs_pkg.sv
// Package of the spring force block: widths, register codes, stage payload types.
// Depends on nothing.
package sfs_pkg;

    localparam int FRAC_BITS = 16;
    localparam int NUM_AX    = 3;
    localparam int ROOT_W    = 34;   // floor(sqrt) of a sum below 2^66
    localparam int REM_W     = 68;   // square root remainder
    localparam int Q_W       = 31;   // unit vector component, Q.30, up to 2^30
    localparam int DREM_W    = 34;   // divider remainder, below the length

    localparam logic [62:0] MAG_CAP = {63{1'b1}};

    // register indexes of the configuration port
    localparam logic [1:0] CFG_STIFF = 2'd0;
    localparam logic [1:0] CFG_REST  = 2'd1;
    localparam logic [1:0] CFG_DAMP  = 2'd2;
    localparam logic [1:0] CFG_DT    = 2'd3;

    // data riding along the square root cells
    typedef struct packed {
        logic [NUM_AX-1:0][31:0] dm;
        logic [NUM_AX-1:0]       dneg;
        logic [31:0]             sa;
        logic [31:0]             sb;
    } t_sq_side;

    // divider state of the three axes
    typedef struct packed {
        logic [NUM_AX-1:0][DREM_W-1:0] rem;
        logic [NUM_AX-1:0][Q_W-1:0]    quo;
        logic [NUM_AX-1:0]             lsb;
    } t_div_lane;

    // data riding along the divider cells
    typedef struct packed {
        logic [ROOT_W-1:0] len;
        logic [ROOT_W-1:0] dispm;
        logic              dispneg;
        logic              skip;
        logic [NUM_AX-1:0] dneg;
        logic [31:0]       sa;
        logic [31:0]       sb;
    } t_div_side;

endpackage

FILE: hw/rtl/sfs_sqrt_cell.sv
// One bit of the pipelined integer square root.
// Depends on sfs_pkg.
module sfs_sqrt_cell #(
    parameter int BIT = 0
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [67:0]               i_rem,
    input  logic [33:0]               i_root,
    input  sfs_pkg::t_sq_side         i_side,
    output logic                      o_valid,
    output logic [67:0]               o_rem,
    output logic [33:0]               o_root,
    output sfs_pkg::t_sq_side         o_side
);
    import sfs_pkg::*;

    logic [REM_W-1:0] trial;
    logic             take;

    // (r + 2^b)^2 - r^2 = r * 2^(b+1) + 2^(2b)
    always_comb begin
        trial = ({{(REM_W-ROOT_W){1'b0}}, i_root} << (BIT + 1))
              + ({{(REM_W-1){1'b0}}, 1'b1} << (2 * BIT));
        take  = (i_rem >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem  <= take ? (i_rem - trial) : i_rem;
            o_root <= take ? (i_root | ({{(ROOT_W-1){1'b0}}, 1'b1} << BIT)) : i_root;
            o_side <= i_side;
        end
    end

endmodule

FILE: hw/rtl/sfs_div_cell.sv
// One quotient bit of the three pipelined restoring dividers (axis / length).
// Depends on sfs_pkg.
module sfs_div_cell #(
    parameter int BIT = 0
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  sfs_pkg::t_div_lane        i_lane,
    input  sfs_pkg::t_div_side        i_side,
    output logic                      o_valid,
    output sfs_pkg::t_div_lane        o_lane,
    output sfs_pkg::t_div_side        o_side
);
    import sfs_pkg::*;

    logic [DREM_W:0]  cur  [NUM_AX];
    logic [DREM_W:0]  diff [NUM_AX];
    logic             ge   [NUM_AX];
    t_div_lane        n_lane;

    // shift in the next dividend bit; only the top step sees the axis lsb
    always_comb begin
        n_lane = i_lane;
        for (int a = 0; a < NUM_AX; a++) begin
            cur[a]  = {i_lane.rem[a], (BIT == Q_W - 1) ? i_lane.lsb[a] : 1'b0};
            diff[a] = cur[a] - {1'b0, i_side.len};
            ge[a]   = (cur[a] >= {1'b0, i_side.len});
            n_lane.rem[a] = ge[a] ? diff[a][DREM_W-1:0] : cur[a][DREM_W-1:0];
            n_lane.quo[a] = i_lane.quo[a] | ({{(Q_W-1){1'b0}}, ge[a]} << BIT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_lane <= n_lane;
            o_side <= i_side;
        end
    end

endmodule

FILE: hw/rtl/sfs_force_lane.sv
// Force scaling of one axis: stretch, stiffness, damping, dt * inverse mass.
// Five register stages, saturated outputs for both ends. Depends on sfs_pkg.
module sfs_force_lane #(
    parameter int AXIS = 0
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [30:0]               i_unit,
    input  sfs_pkg::t_div_side        i_side,
    input  logic [30:0]               i_stiff,
    input  logic [16:0]               i_keep,
    output logic [31:0]               o_dv_a,
    output logic [31:0]               o_dv_b
);
    import sfs_pkg::*;

    logic [64:0] r_p1;
    logic [65:0] r_p2;
    logic [79:0] r_p3;
    logic [63:0] r_lo_a, r_lo_b;
    logic [47:0] r_hi_a, r_hi_b;
    logic [3:0]  r_fneg, r_skip;
    logic [31:0] r_sa [3];
    logic [31:0] r_sb [3];

    logic [34:0] m1;
    logic [62:0] m2;
    logic [47:0] m3c;
    logic [79:0] sum_a, sum_b;

    function automatic logic [31:0] sat_mag(input logic [63:0] mag, input logic neg);
        logic big;
        begin
            big = |mag[63:31];
            if (neg) begin
                return big ? 32'h8000_0000 : (~mag[31:0] + 32'd1);
            end
            return big ? 32'h7FFF_FFFF : mag[31:0];
        end
    endfunction

    // clamp steps; m3 beyond 2^47 saturates every nonzero output anyway
    always_comb begin
        m1    = r_p1[64:30];
        m2    = (|r_p2[65:64]) ? MAG_CAP : {15'd0, r_p2[63:FRAC_BITS]};
        m3c   = (|r_p3[79:63]) ? {1'b1, 47'd0} : {1'b0, r_p3[62:16]};
        sum_a = {r_hi_a, 32'd0} + {16'd0, r_lo_a};
        sum_b = {r_hi_b, 32'd0} + {16'd0, r_lo_b};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // unit * stretch
            r_p1      <= 65'(i_unit) * 65'(i_side.dispm);
            r_fneg[0] <= i_side.dneg[AXIS] ^ i_side.dispneg;
            r_skip[0] <= i_side.skip;
            r_sa[0]   <= i_side.sa;
            r_sb[0]   <= i_side.sb;
            // times stiffness
            r_p2      <= 66'(m1) * 66'(i_stiff);
            r_fneg[1] <= r_fneg[0];
            r_skip[1] <= r_skip[0];
            r_sa[1]   <= r_sa[0];
            r_sb[1]   <= r_sb[0];
            // times one minus damping
            r_p3      <= 80'(m2) * 80'(i_keep);
            r_fneg[2] <= r_fneg[1];
            r_skip[2] <= r_skip[1];
            r_sa[2]   <= r_sa[1];
            r_sb[2]   <= r_sb[1];
            // partial products with dt * inverse mass
            r_lo_a    <= 64'(m3c[31:0]) * 64'(r_sa[2]);
            r_hi_a    <= 48'(m3c[47:32]) * 48'(r_sa[2]);
            r_lo_b    <= 64'(m3c[31:0]) * 64'(r_sb[2]);
            r_hi_b    <= 48'(m3c[47:32]) * 48'(r_sb[2]);
            r_fneg[3] <= r_fneg[2];
            r_skip[3] <= r_skip[2];
            // output register; end a takes the opposite sign
            o_dv_a    <= r_skip[3] ? 32'd0 : sat_mag(sum_a[79:FRAC_BITS], !r_fneg[3]);
            o_dv_b    <= r_skip[3] ? 32'd0 : sat_mag(sum_b[79:FRAC_BITS], r_fneg[3]);
        end
    end

endmodule

FILE: hw/rtl/spring_force_step.sv
// Top level of the spring force block: input stages, square root and divider
// cell chains, three force lanes. Depends on sfs_pkg, assert_macros.svh, submodules.
//
// Takes one spring item per cycle and returns its end velocity changes after
// three input stages, a chain of 34 square root cells (one root bit each), one
// stretch stage, a chain of 31 divider cells (one unit-vector bit each, all
// three axes side by side) and five multiply stages. Every stage
// moves together; while a result sits in the output register untaken, the whole
// pipeline holds and the input is not ready.
module spring_force_step (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // fields from bit 0: pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z,
    // inv_mass_a, inv_mass_b, 2 zero bits
    input  logic [255:0] i_s_axis_tdata,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // fields from bit 0: dv_a_x, dv_a_y, dv_a_z, dv_b_x, dv_b_y, dv_b_z
    output logic [191:0] o_m_axis_tdata,
    // fields from bit 0: skipped
    output logic [0:0]   o_m_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    input  logic         i_cfg_wr_en,
    input  logic [1:0]   i_cfg_index,
    input  logic [30:0]  i_cfg_wdata
);
    import sfs_pkg::*;

    localparam int SQ_N  = ROOT_W;
    localparam int DIV_N = Q_W;

    logic        en;
    logic        accept;

    logic [30:0] r_stiff, r_rest;
    logic [16:0] r_damp, r_dt;
    logic [16:0] keep;

    t_sq_side    n_s1_side;
    logic        r_s1_v, r_s2_v, r_s3_v, r_s4_v;
    t_sq_side    r_s1_side, r_s2_side, r_s3_side;
    logic [NUM_AX-1:0][63:0] r_sq;
    logic [65:0] r_sum;

    logic              w_sq_v    [0:SQ_N];
    logic [67:0]       w_sq_rem  [0:SQ_N];
    logic [33:0]       w_sq_root [0:SQ_N];
    t_sq_side          w_sq_side [0:SQ_N];

    t_div_side   n_s4_side;
    t_div_lane   n_s4_lane;
    t_div_side   r_s4_side;
    t_div_lane   r_s4_lane;

    logic        w_dv_v    [0:DIV_N];
    t_div_lane   w_dv_lane [0:DIV_N];
    t_div_side   w_dv_side [0:DIV_N];

    logic [4:0]  r_tail_v, r_tail_skip;
    logic [NUM_AX-1:0][31:0] dv_a, dv_b;

    // whole pipeline advances unless the output item is stuck
    assign en              = !r_tail_v[4] || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && en;
    assign o_s_axis_tready = en;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stiff <= 31'd65536;
            r_rest  <= 31'd65536;
            r_damp  <= 17'd0;
            r_dt    <= 17'd1092;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_STIFF: r_stiff <= i_cfg_wdata;
                CFG_REST:  r_rest  <= i_cfg_wdata;
                CFG_DAMP:  r_damp  <= i_cfg_wdata[16:0];
                CFG_DT:    r_dt    <= i_cfg_wdata[16:0];
                default:   ;
            endcase
        end
    end

    // damping above one removes the whole force
    assign keep = 17'd65536 - ((r_damp > 17'd65536) ? 17'd65536 : r_damp);

    // stage 1: separation magnitudes and dt * inverse mass
    always_comb begin
        logic [32:0] d;
        logic [47:0] pa, pb;
        for (int a = 0; a < NUM_AX; a++) begin
            d = {i_s_axis_tdata[32*a+31], i_s_axis_tdata[32*a +: 32]}
              - {i_s_axis_tdata[32*(a+3)+31], i_s_axis_tdata[32*(a+3) +: 32]};
            n_s1_side.dneg[a] = d[32];
            n_s1_side.dm[a]   = d[32] ? (~d[31:0] + 32'd1) : d[31:0];
        end
        pa = 48'(r_dt) * 48'(i_s_axis_tdata[222:192]);
        pb = 48'(r_dt) * 48'(i_s_axis_tdata[253:223]);
        n_s1_side.sa = pa[47:FRAC_BITS];
        n_s1_side.sb = pb[47:FRAC_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= accept;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
        end
    end

    // stages 2 and 3: squares, then their sum
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_side <= n_s1_side;
            for (int a = 0; a < NUM_AX; a++) begin
                r_sq[a] <= 64'(r_s1_side.dm[a]) * 64'(r_s1_side.dm[a]);
            end
            r_s2_side <= r_s1_side;
            r_sum     <= 66'(r_sq[0]) + 66'(r_sq[1]) + 66'(r_sq[2]);
            r_s3_side <= r_s2_side;
        end
    end

    // square root chain, most significant root bit first
    assign w_sq_v[0]    = r_s3_v;
    assign w_sq_rem[0]  = 68'(r_sum);
    assign w_sq_root[0] = '0;
    assign w_sq_side[0] = r_s3_side;

    for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
        sfs_sqrt_cell #(.BIT(SQ_N - 1 - k)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (w_sq_v[k]),
            .i_rem   (w_sq_rem[k]),
            .i_root  (w_sq_root[k]),
            .i_side  (w_sq_side[k]),
            .o_valid (w_sq_v[k+1]),
            .o_rem   (w_sq_rem[k+1]),
            .o_root  (w_sq_root[k+1]),
            .o_side  (w_sq_side[k+1])
        );
    end

    // stage 4: stretch, zero-length check, divider start
    always_comb begin
        logic [33:0] len;
        logic [33:0] rest;
        len  = w_sq_root[SQ_N];
        rest = {3'd0, r_rest};
        n_s4_side.len     = len;
        n_s4_side.dispneg = (len < rest);
        n_s4_side.dispm   = (len < rest) ? (rest - len) : (len - rest);
        n_s4_side.skip    = (len == '0);
        n_s4_side.dneg    = w_sq_side[SQ_N].dneg;
        n_s4_side.sa      = w_sq_side[SQ_N].sa;
        n_s4_side.sb      = w_sq_side[SQ_N].sb;
        for (int a = 0; a < NUM_AX; a++) begin
            n_s4_lane.rem[a] = {3'd0, w_sq_side[SQ_N].dm[a][31:1]};
            n_s4_lane.quo[a] = '0;
            n_s4_lane.lsb[a] = w_sq_side[SQ_N].dm[a][0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_v <= 1'b0;
        end else if (en) begin
            r_s4_v <= w_sq_v[SQ_N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s4_side <= n_s4_side;
            r_s4_lane <= n_s4_lane;
        end
    end

    // divider chain: (|d| << 30) / length
    assign w_dv_v[0]    = r_s4_v;
    assign w_dv_lane[0] = r_s4_lane;
    assign w_dv_side[0] = r_s4_side;

    for (genvar k = 0; k < DIV_N; k++) begin : g_div
        sfs_div_cell #(.BIT(DIV_N - 1 - k)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (w_dv_v[k]),
            .i_lane  (w_dv_lane[k]),
            .i_side  (w_dv_side[k]),
            .o_valid (w_dv_v[k+1]),
            .o_lane  (w_dv_lane[k+1]),
            .o_side  (w_dv_side[k+1])
        );
    end

    // force lanes
    for (genvar a = 0; a < NUM_AX; a++) begin : g_lane
        sfs_force_lane #(.AXIS(a)) u_lane (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_unit  (w_dv_lane[DIV_N].quo[a]),
            .i_side  (w_dv_side[DIV_N]),
            .i_stiff (r_stiff),
            .i_keep  (keep),
            .o_dv_a  (dv_a[a]),
            .o_dv_b  (dv_b[a])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail_v <= '0;
        end else if (en) begin
            r_tail_v <= {r_tail_v[3:0], w_dv_v[DIV_N]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tail_skip <= {r_tail_skip[3:0], w_dv_side[DIV_N].skip};
        end
    end

    assign o_m_axis_tvalid = r_tail_v[4];
    assign o_m_axis_tuser  = r_tail_skip[4];
    assign o_m_axis_tdata  = {dv_b[2], dv_b[1], dv_b[0], dv_a[2], dv_a[1], dv_a[0]};

    `include "assert_macros.svh"

    // zero separation gives all-zero velocity changes
    `ASSERT_IMPL(a_skip_zero, i_clk, i_rst_n,
        o_m_axis_tvalid && o_m_axis_tuser[0], o_m_axis_tdata == '0)
    // floor square root leaves a remainder of at most twice the root
    `ASSERT_IMPL(a_root_rem, i_clk, i_rst_n, w_sq_v[SQ_N],
        w_sq_rem[SQ_N] <= {33'd0, w_sq_root[SQ_N], 1'b0})
    // unit vector components never exceed one
    `ASSERT_IMPL(a_unit_range, i_clk, i_rst_n, w_dv_v[DIV_N] && !w_dv_side[DIV_N].skip,
        (w_dv_lane[DIV_N].quo[0] <= 31'h4000_0000)
        && (w_dv_lane[DIV_N].quo[1] <= 31'h4000_0000)
        && (w_dv_lane[DIV_N].quo[2] <= 31'h4000_0000))

endmodule
